@@ rtl/core/pbrg_pkg.sv @@
// Shared widths, register indexes and types of the portamento bend ramp generator.
package pbrg_pkg;

   localparam int MAX_STEPS_DEF = 63;
   localparam int MIN_STEPS     = 2;

   localparam int BEAT_W     = 18;
   localparam int SPB_W      = 20;
   localparam int PITCH_W    = 7;
   localparam int WEIGHT_W   = 9;
   localparam int BSTEPS_W   = 6;
   localparam int TIME_W     = 31;
   localparam int BEND_W     = 14;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 20;

   localparam logic [SPB_W-1:0]    SPB_RESET    = 20'd32768;
   localparam logic [BSTEPS_W-1:0] BSTEPS_RESET = 6'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_SECONDS_PER_BEAT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEND_STEPS       = 1'd1;

   localparam logic [BEND_W-1:0] BEND_CENTRE = 14'd8192;
   localparam logic [BEND_W-1:0] BEND_MAX    = 14'd16383;

   // Shared multiplier operands and product.
   localparam int MUL_W  = 22;
   localparam int PROD_W = 2 * MUL_W;

   // Shared divider: remainder width, quotient width and iteration counts.
   localparam int DIV_W       = 36;
   localparam int QUO_W       = 29;
   localparam int ITER_W      = 5;
   localparam int SPAN_SHIFT  = 28;
   localparam int BEND_SHIFT  = 13;
   localparam int OVF_SHIFT   = 14;
   localparam logic [ITER_W-1:0] SPAN_ITERS = 5'd29;
   localparam logic [ITER_W-1:0] BEND_ITERS = 5'd14;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DIV_W-1:0]  divisor;
      logic [ITER_W-1:0] iters;
   } div_cmd_type;

   typedef struct packed {
      logic              busy;
      logic [QUO_W-1:0]  quotient;
      logic [DIV_W-1:0]  remainder;
   } div_res_type;

endpackage

@@ rtl/core/pbrg_if.sv @@
// Valid/ready channel interfaces for slide requests and pitch-wheel responses.
interface pbrg_req_if;
   logic                          valid;
   logic                          ready;
   logic [pbrg_pkg::BEAT_W-1:0]   start_beat;
   logic [pbrg_pkg::BEAT_W-1:0]   end_beat;
   logic [pbrg_pkg::PITCH_W-1:0]  from_pitch;
   logic [pbrg_pkg::PITCH_W-1:0]  to_pitch;
   logic [pbrg_pkg::WEIGHT_W-1:0] curve_weight;

   modport source (output valid, start_beat, end_beat, from_pitch, to_pitch, curve_weight,
                   input ready);
   modport sink (input valid, start_beat, end_beat, from_pitch, to_pitch, curve_weight,
                 output ready);
endinterface

interface pbrg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pbrg_pkg::TIME_W-1:0] event_time;
   logic [pbrg_pkg::BEND_W-1:0] bend_value;
   logic                        last_event;

   modport source (output valid, event_time, bend_value, last_event, input ready);
   modport sink (input valid, event_time, bend_value, last_event, output ready);
endinterface

@@ rtl/core/portamento_bend_ramp_generator.sv @@
// Portamento bend ramp generator: expands each slide into a ramp of pitch-wheel events.
//
// The request channel takes one slide per beat: start and end position in beats, the
// from and to notes and a curve weight. For each slide the response channel delivers
// steps+1 beats, steps being bend_steps raised to at least two and capped at MAX_STEPS,
// each carrying a timestamp in 2^-16 s units and a 14-bit wheel position; last_event
// marks the final one. A slide taken while seconds_per_beat is zero yields no response at all.
// The CSR port writes seconds_per_beat (index 0) and bend_steps (index 1); write only
// while the block is idle.
// Sequence: set-up runs the multiplier states from the accepted beat and is dominated
// by the span division in the shared divider. Each event then passes through a start
// state, the shared divider for the bend quotient, a wait state that sees it finish
// and an emit state. The request side is not ready until the last event of the slide
// has been placed in the output register.
// A held-off response waits in the output register; the sequencer prepares the next event
// and then pauses in its emit state until the response is taken. Reset restores the
// register defaults, clears the sequencer and drops any response that was waiting.
module portamento_bend_ramp_generator #(
   parameter int MAX_STEPS = pbrg_pkg::MAX_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   pbrg_req_if.sink                           req_bus,
   pbrg_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [pbrg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pbrg_pkg::CSR_DATA_W-1:0]    csr_data
);
   import pbrg_pkg::*;

   localparam int STEP_W = $clog2(MAX_STEPS + 1);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MUL_ST  = 4'd1;
   localparam logic [3:0] S_MUL_ET  = 4'd2;
   localparam logic [3:0] S_MUL_SQ  = 4'd3;
   localparam logic [3:0] S_MUL_A   = 4'd4;
   localparam logic [3:0] S_MUL_P   = 4'd5;
   localparam logic [3:0] S_MUL_DP  = 4'd6;
   localparam logic [3:0] S_MUL_DDP = 4'd7;
   localparam logic [3:0] S_MUL_END = 4'd8;
   localparam logic [3:0] S_SPAN    = 4'd9;
   localparam logic [3:0] S_BSTART  = 4'd10;
   localparam logic [3:0] S_BDIV    = 4'd11;
   localparam logic [3:0] S_EMIT    = 4'd12;

   logic [3:0]              state_ff, state_in;
   logic [SPB_W-1:0]        spb_ff, spb_in;
   logic [BSTEPS_W-1:0]     bsteps_ff, bsteps_in;

   logic [BEAT_W-1:0]       sb_ff, sb_in;
   logic [BEAT_W-1:0]       eb_ff, eb_in;
   logic signed [7:0]       delta_ff, delta_in;
   logic [WEIGHT_W-1:0]     w_ff, w_in;
   logic [STEP_W-1:0]       steps_ff, steps_in;
   logic [29:0]             st_ff, st_in;
   logic [29:0]             et_ff, et_in;
   logic [11:0]             sq_ff, sq_in;
   logic signed [16:0]      a_ff, a_in;
   logic signed [31:0]      p_ff, p_in;
   logic signed [31:0]      dp_ff, dp_in;
   logic signed [31:0]      ddp_ff, ddp_in;
   logic [QUO_W-1:0]        qstep_ff, qstep_in;
   logic [STEP_W-1:0]       rstep_ff, rstep_in;
   logic [29:0]             qacc_ff, qacc_in;
   logic [STEP_W-1:0]       racc_ff, racc_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    neg_ff, neg_in;
   logic                    ovf_ff, ovf_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]       time_ff, time_in;
   logic [BEND_W-1:0]       bend_ff, bend_in;
   logic                    last_ff, last_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_prod;
   div_cmd_type             div_cmd;
   div_res_type             div_res;

   logic                    req_take;
   logic                    out_free;
   logic                    last_now;
   logic [STEP_W-1:0]       steps_sel;
   logic [29:0]             span;
   logic signed [9:0]       wm;
   logic signed [MUL_W-1:0] delta_x;
   logic signed [MUL_W-1:0] aw;
   logic [13:0]             sq3;
   logic [14:0]             dsor;
   logic signed [DIV_W-1:0] nval;
   logic [DIV_W-1:0]        mprime;
   logic [BEND_W-1:0]       qbend;
   logic [BEND_W-1:0]       bend_calc;
   logic [STEP_W:0]         rsum;

   pbrg_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (mul_prod)
   );

   pbrg_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign last_now      = (step_ff == steps_ff);

   // Steps below two act as two; anything above the cap is held at the cap.
   always_comb begin
      if (bsteps_ff < BSTEPS_W'(MIN_STEPS)) begin
         steps_sel = STEP_W'(MIN_STEPS);
      end else if (bsteps_ff > BSTEPS_W'(MAX_STEPS)) begin
         steps_sel = STEP_W'(MAX_STEPS);
      end else begin
         steps_sel = STEP_W'(bsteps_ff);
      end
   end

   assign span    = (et_ff > st_ff) ? (et_ff - st_ff) : 30'd1;
   assign wm      = $signed(10'd256) - $signed({1'b0, w_ff});
   assign delta_x = MUL_W'(delta_ff);
   assign aw      = MUL_W'(a_ff) + $signed({13'b0, w_ff});

   // The bend numerator is 16*P + 3*steps^2 over the divisor 6*steps^2. A negative
   // numerator is divided as a floor, a ceiling on its magnitude taken as floor((~N + D)/D).
   assign sq3    = {1'b0, sq_ff, 1'b0} + {2'b0, sq_ff};
   assign dsor   = {sq3, 1'b0};
   assign nval   = $signed({p_ff, 4'b0}) + $signed({22'b0, sq3});
   assign mprime = nval[DIV_W-1] ? (~nval + DIV_W'(dsor)) : nval;
   assign qbend  = div_res.quotient[BEND_W-1:0];
   assign rsum   = {1'b0, racc_ff} + {1'b0, rstep_ff};

   always_comb begin
      if (!neg_ff) begin
         if (ovf_ff || qbend >= (BEND_CENTRE - 1'b1)) begin
            bend_calc = BEND_MAX;
         end else begin
            bend_calc = BEND_CENTRE + qbend;
         end
      end else begin
         if (ovf_ff || qbend >= BEND_CENTRE) begin
            bend_calc = '0;
         end else begin
            bend_calc = BEND_CENTRE - qbend;
         end
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MUL_ST: begin
            mul_a = $signed({4'b0, sb_ff});
            mul_b = $signed({2'b0, spb_ff});
         end
         S_MUL_ET: begin
            mul_a = $signed({4'b0, eb_ff});
            mul_b = $signed({2'b0, spb_ff});
         end
         S_MUL_SQ: begin
            mul_a = $signed(MUL_W'(steps_ff));
            mul_b = $signed(MUL_W'(steps_ff));
         end
         S_MUL_A: begin
            mul_a = MUL_W'(wm);
            mul_b = $signed(MUL_W'(steps_ff));
         end
         S_MUL_P: begin
            mul_a = delta_x;
            mul_b = -$signed({2'b0, sq_ff, 8'b0});
         end
         S_MUL_DP: begin
            mul_a = delta_x;
            mul_b = aw;
         end
         S_MUL_DDP: begin
            mul_a = delta_x;
            mul_b = $signed({12'b0, w_ff, 1'b0});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      spb_in       = spb_ff;
      bsteps_in    = bsteps_ff;
      sb_in        = sb_ff;
      eb_in        = eb_ff;
      delta_in     = delta_ff;
      w_in         = w_ff;
      steps_in     = steps_ff;
      st_in        = st_ff;
      et_in        = et_ff;
      sq_in        = sq_ff;
      a_in         = a_ff;
      p_in         = p_ff;
      dp_in        = dp_ff;
      ddp_in       = ddp_ff;
      qstep_in     = qstep_ff;
      rstep_in     = rstep_ff;
      qacc_in      = qacc_ff;
      racc_in      = racc_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      ovf_in       = ovf_ff;
      time_in      = time_ff;
      bend_in      = bend_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_bus.ready ? 1'b0 : rsp_valid_ff;
      div_cmd      = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_SECONDS_PER_BEAT: spb_in    = csr_data[SPB_W-1:0];
            CSR_BEND_STEPS:       bsteps_in = csr_data[BSTEPS_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               sb_in    = req_bus.start_beat;
               eb_in    = req_bus.end_beat;
               delta_in = $signed({1'b0, req_bus.to_pitch}) - $signed({1'b0, req_bus.from_pitch});
               w_in     = req_bus.curve_weight;
               steps_in = steps_sel;
               // With no tempo the slide is swallowed without a response.
               if (spb_ff != '0) begin
                  state_in = S_MUL_ST;
               end
            end
         end
         S_MUL_ST: begin
            state_in = S_MUL_ET;
         end
         S_MUL_ET: begin
            st_in    = mul_prod[37:8];
            state_in = S_MUL_SQ;
         end
         S_MUL_SQ: begin
            et_in    = mul_prod[37:8];
            state_in = S_MUL_A;
         end
         S_MUL_A: begin
            sq_in            = mul_prod[11:0];
            div_cmd.start    = 1'b1;
            div_cmd.dividend = DIV_W'(span);
            div_cmd.divisor  = DIV_W'(steps_ff) << SPAN_SHIFT;
            div_cmd.iters    = SPAN_ITERS;
            state_in         = S_MUL_P;
         end
         S_MUL_P: begin
            a_in     = $signed(mul_prod[16:0]);
            state_in = S_MUL_DP;
         end
         S_MUL_DP: begin
            p_in     = $signed(mul_prod[31:0]);
            state_in = S_MUL_DDP;
         end
         S_MUL_DDP: begin
            dp_in    = $signed(mul_prod[31:0]);
            state_in = S_MUL_END;
         end
         S_MUL_END: begin
            ddp_in   = $signed(mul_prod[31:0]);
            state_in = S_SPAN;
         end
         S_SPAN: begin
            if (!div_res.busy) begin
               qstep_in = div_res.quotient;
               rstep_in = div_res.remainder[STEP_W-1:0];
               qacc_in  = '0;
               racc_in  = '0;
               step_in  = '0;
               state_in = S_BSTART;
            end
         end
         S_BSTART: begin
            neg_in           = nval[DIV_W-1];
            ovf_in           = (mprime >= (DIV_W'(dsor) << OVF_SHIFT));
            div_cmd.start    = 1'b1;
            div_cmd.dividend = mprime;
            div_cmd.divisor  = DIV_W'(dsor) << BEND_SHIFT;
            div_cmd.iters    = BEND_ITERS;
            state_in         = S_BDIV;
         end
         S_BDIV: begin
            if (!div_res.busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               time_in      = TIME_W'(st_ff) + TIME_W'(qacc_ff);
               bend_in      = bend_calc;
               last_in      = last_now;
               // Advance the time fraction span*s/steps and the bend polynomial by one step.
               p_in         = p_ff + dp_ff;
               dp_in        = dp_ff + ddp_ff;
               if (rsum >= {1'b0, steps_ff}) begin
                  racc_in = STEP_W'(rsum - {1'b0, steps_ff});
                  qacc_in = qacc_ff + 30'(qstep_ff) + 30'd1;
               end else begin
                  racc_in = STEP_W'(rsum);
                  qacc_in = qacc_ff + 30'(qstep_ff);
               end
               step_in  = step_ff + 1'b1;
               state_in = last_now ? S_IDLE : S_BSTART;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         spb_ff       <= SPB_RESET;
         bsteps_ff    <= BSTEPS_RESET;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         spb_ff       <= spb_in;
         bsteps_ff    <= bsteps_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
      sb_ff    <= sb_in;
      eb_ff    <= eb_in;
      delta_ff <= delta_in;
      w_ff     <= w_in;
      steps_ff <= steps_in;
      st_ff    <= st_in;
      et_ff    <= et_in;
      sq_ff    <= sq_in;
      a_ff     <= a_in;
      p_ff     <= p_in;
      dp_ff    <= dp_in;
      ddp_ff   <= ddp_in;
      qstep_ff <= qstep_in;
      rstep_ff <= rstep_in;
      qacc_ff  <= qacc_in;
      racc_ff  <= racc_in;
      neg_ff   <= neg_in;
      ovf_ff   <= ovf_in;
      time_ff  <= time_in;
      bend_ff  <= bend_in;
      last_ff  <= last_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.event_time = time_ff;
   assign rsp_bus.bend_value = bend_ff;
   assign rsp_bus.last_event = last_ff;

   // The divider is only ever started when it has finished its previous job.
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !div_res.busy)
      else $error("divider started while busy");

   // A new slide is only taken once the shared divider has gone quiet.
   a_div_idle_on_ready: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !div_res.busy)
      else $error("request side ready with divider still busy");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_MUL_ST) |-> (step_ff <= steps_ff || state_ff < S_BSTART))
      else $error("step index ran past the ramp length");

   // The ramp always ends exactly on the target note.
   a_last_centred: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.last_event) |-> (rsp_bus.bend_value == BEND_CENTRE))
      else $error("final event of a ramp is not centred");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free && last_now)
         |=> (state_ff == S_IDLE && rsp_bus.valid && rsp_bus.last_event))
      else $error("sequencer did not finish the slide on its last event");

endmodule

@@ rtl/core/pbrg_mul.sv @@
// Shared signed multiplier with a registered product.
module pbrg_mul (
   input  logic                                clock,
   input  logic signed [pbrg_pkg::MUL_W-1:0]   mul_a,
   input  logic signed [pbrg_pkg::MUL_W-1:0]   mul_b,
   output logic signed [pbrg_pkg::PROD_W-1:0]  prod
);
   import pbrg_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ rtl/core/pbrg_div.sv @@
// Restoring divider, one quotient bit a cycle, with a pre-shifted divisor.
module pbrg_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pbrg_pkg::div_cmd_type cmd,
   output pbrg_pkg::div_res_type res
);
   import pbrg_pkg::*;

   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dvs_ff, dvs_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              take;

   assign take = (rem_ff >= dvs_ff);

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (cmd.start) begin
         rem_in  = cmd.dividend;
         dvs_in  = cmd.divisor;
         quo_in  = '0;
         cnt_in  = cmd.iters;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (take) begin
            rem_in = rem_ff - dvs_ff;
         end
         quo_in  = {quo_ff[QUO_W-2:0], take};
         dvs_in  = dvs_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != ITER_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign res.busy      = busy_ff;
   assign res.quotient  = quo_ff;
   assign res.remainder = rem_ff;

endmodule

@@ verif/portamento_bend_ramp_generator_tb.sv @@
// Self-checking testbench for the portamento bend ramp generator: directed table, then random slides.
`timescale 1ns / 100ps

module portamento_bend_ramp_generator_tb;
   import pbrg_pkg::*;

   localparam int CYCLE_LIMIT   = 3000000;
   localparam int DRAIN_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 100;
   localparam int TAIL_CYCLES   = 100;
   localparam int LONG_HOLD     = 800;
   localparam int RANDOM_SLIDES = 250;
   localparam int N_DIRECTED    = 20;

   typedef struct packed {
      logic [BEAT_W-1:0]   start_beat;
      logic [BEAT_W-1:0]   end_beat;
      logic [PITCH_W-1:0]  from_pitch;
      logic [PITCH_W-1:0]  to_pitch;
      logic [WEIGHT_W-1:0] curve_weight;
   } slide_type;

   typedef struct packed {
      logic [TIME_W-1:0] event_time;
      logic [BEND_W-1:0] bend_value;
      logic              last_event;
   } ramp_event_type;

   typedef struct packed {
      logic [SPB_W-1:0]    spb;
      logic [BSTEPS_W-1:0] steps;
      slide_type           slide;
      logic                pinned;
      logic [BEND_W-1:0]   first_bend;
      logic [BEND_W-1:0]   last_bend;
   } ramp_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   pbrg_req_if req_bus ();
   pbrg_rsp_if rsp_bus ();

   portamento_bend_ramp_generator uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Shadow copy of the registers, as last written.
   logic [SPB_W-1:0]    tempo_spb  = SPB_RESET;
   logic [BSTEPS_W-1:0] ramp_steps = BSTEPS_RESET;

   ramp_event_type awaited_events [$];
   int unsigned cycle_count  = 0;
   int unsigned mismatches   = 0;
   int unsigned slides_taken = 0;
   bit          steady_phase = 1'b0;
   bit          hold_wanted  = 1'b0;

   // The first and final wheel positions are typed in where they follow directly from
   // saturation (an interval of a dozen semitones or more) or from an unchanged pitch.
   ramp_row_type directed_rows [N_DIRECTED] = '{
      '{SPB_RESET, BSTEPS_RESET, '{18'd0, 18'd0, 7'd60, 7'd60, 9'd0},
        1'b1, BEND_CENTRE, BEND_CENTRE},
      '{SPB_RESET, BSTEPS_RESET, '{18'd0, 18'd256, 7'd0, 7'd127, 9'd0},
        1'b1, 14'd0, BEND_CENTRE},
      '{SPB_RESET, BSTEPS_RESET, '{18'd256, 18'd512, 7'd127, 7'd0, 9'd256},
        1'b1, BEND_MAX, BEND_CENTRE},
      '{SPB_RESET, BSTEPS_RESET, '{18'd262143, 18'd0, 7'd0, 7'd127, 9'd511},
        1'b1, 14'd0, BEND_CENTRE},
      '{SPB_RESET, BSTEPS_RESET, '{18'd0, 18'd262143, 7'd64, 7'd65, 9'd128},
        1'b0, 14'd0, 14'd0},
      '{SPB_RESET, BSTEPS_RESET, '{18'd100, 18'd101, 7'd72, 7'd60, 9'd1},
        1'b0, 14'd0, 14'd0},
      '{SPB_RESET, 6'd0, '{18'd0, 18'd1024, 7'd0, 7'd127, 9'd0},
        1'b1, 14'd0, BEND_CENTRE},
      '{SPB_RESET, 6'd1, '{18'd0, 18'd1024, 7'd127, 7'd0, 9'd256},
        1'b1, BEND_MAX, BEND_CENTRE},
      '{SPB_RESET, 6'd2, '{18'd10, 18'd20, 7'd50, 7'd70, 9'd200},
        1'b0, 14'd0, 14'd0},
      '{20'hFFFFF, 6'd63, '{18'd0, 18'd262143, 7'd0, 7'd127, 9'd256},
        1'b1, 14'd0, BEND_CENTRE},
      '{20'hFFFFF, 6'd63, '{18'd262143, 18'd262143, 7'd127, 7'd127, 9'd0},
        1'b1, BEND_CENTRE, BEND_CENTRE},
      '{20'hFFFFF, 6'd63, '{18'd1, 18'd3, 7'd40, 7'd52, 9'd64},
        1'b0, 14'd0, 14'd0},
      '{20'd1, 6'd5, '{18'd1, 18'd2, 7'd0, 7'd127, 9'd0},
        1'b1, 14'd0, BEND_CENTRE},
      '{20'd1, 6'd5, '{18'd262143, 18'd262143, 7'd60, 7'd48, 9'd100},
        1'b0, 14'd0, 14'd0},
      '{20'd0, 6'd5, '{18'd0, 18'd256, 7'd0, 7'd127, 9'd0},
        1'b0, 14'd0, 14'd0},
      '{20'd0, 6'd5, '{18'd262143, 18'd0, 7'd127, 7'd0, 9'd511},
        1'b0, 14'd0, 14'd0},
      '{20'hFFFFF, 6'd5, '{18'd0, 18'd1, 7'd60, 7'd61, 9'd255},
        1'b0, 14'd0, 14'd0},
      '{20'hFFFFF, 6'd5, '{18'd0, 18'd1, 7'd60, 7'd59, 9'd257},
        1'b0, 14'd0, 14'd0},
      '{20'hFFFFF, 6'd5, '{18'd5, 18'd5, 7'd0, 7'd1, 9'd1},
        1'b0, 14'd0, 14'd0},
      '{SPB_RESET, BSTEPS_RESET, '{18'd1000, 18'd2000, 7'd60, 7'd72, 9'd300},
        1'b0, 14'd0, 14'd0}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s, got %0d, expected %0d", cycle_count, what, got, want);
      mismatches++;
   endtask

   // Expands one slide into its ramp of wheel events under the current registers.
   function automatic void expand_ramp(input slide_type sl);
      longint st, et, span, steps, delta, w, s, n, num, den, off, t;
      ramp_event_type ev;
      if (tempo_spb == '0)
         return;
      steps = (ramp_steps < MIN_STEPS) ? MIN_STEPS : ramp_steps;
      if (steps > MAX_STEPS_DEF)
         steps = MAX_STEPS_DEF;
      st = (longint'(sl.start_beat) * longint'(tempo_spb)) >> 8;
      et = (longint'(sl.end_beat) * longint'(tempo_spb)) >> 8;
      span = (et > st) ? et - st : 1;
      delta = longint'(sl.to_pitch) - longint'(sl.from_pitch);
      w = longint'(sl.curve_weight);
      for (s = 0; s <= steps; s++) begin
         t = st + (span * s) / steps;
         if (t > longint'(32'h7FFF_FFFF))
            t = longint'(32'h7FFF_FFFF);
         // Offset from centre is delta*(c-1)*8192/12, rounded with halves upward.
         n = s * (256 - w) * steps + s * s * w - 256 * steps * steps;
         num = 16 * delta * n + 3 * steps * steps;
         den = 6 * steps * steps;
         off = (num >= 0) ? num / den : -((-num + den - 1) / den);
         if (off < -8192)
            off = -8192;
         if (off > 8192)
            off = 8192;
         off = off + 8192;
         if (off > 16383)
            off = 16383;
         ev.event_time = t[TIME_W-1:0];
         ev.bend_value = off[BEND_W-1:0];
         ev.last_event = (s == steps);
         awaited_events.insert(awaited_events.size(), ev);
      end
   endfunction

   function automatic slide_type random_slide();
      slide_type   sl;
      int unsigned pick;
      int          stop;
      sl.start_beat = ($urandom_range(1) == 0) ? BEAT_W'($urandom) : BEAT_W'($urandom_range(4095));
      pick = $urandom_range(99);
      if (pick < 80) begin
         stop = int'(sl.start_beat) + int'($urandom_range(4096, 1));
         sl.end_beat = (stop > 262143) ? 18'd262143 : BEAT_W'(stop);
      end else if (pick < 90) begin
         sl.end_beat = sl.start_beat;
      end else begin
         sl.end_beat = BEAT_W'($urandom);
      end
      sl.from_pitch = PITCH_W'($urandom);
      sl.to_pitch = ($urandom_range(4) == 0) ? sl.from_pitch : PITCH_W'($urandom);
      sl.curve_weight = ($urandom_range(4) == 0) ? WEIGHT_W'($urandom_range(511))
                                                  : WEIGHT_W'($urandom_range(256));
      return sl;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_slide(input slide_type sl, input logic pinned,
                             input logic [BEND_W-1:0] first_bend,
                             input logic [BEND_W-1:0] last_bend);
      int first_idx;
      req_bus.valid        <= 1'b1;
      req_bus.start_beat   <= sl.start_beat;
      req_bus.end_beat     <= sl.end_beat;
      req_bus.from_pitch   <= sl.from_pitch;
      req_bus.to_pitch     <= sl.to_pitch;
      req_bus.curve_weight <= sl.curve_weight;
      do @(posedge clock); while (!req_bus.ready);
      first_idx = awaited_events.size();
      expand_ramp(sl);
      if (pinned && awaited_events.size() > first_idx) begin
         awaited_events[first_idx].bend_value = first_bend;
         awaited_events[awaited_events.size() - 1].bend_value = last_bend;
      end
      slides_taken++;
      @(negedge clock);
   endtask

   task automatic idle_sender();
      if (!steady_phase && $urandom_range(99) < 35) begin
         req_bus.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < 35);
      end
   endtask

   // Waits for the ramp in flight to finish, then for a dropped slide to clear.
   task automatic settle_idle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (awaited_events.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_ramp(input logic [SPB_W-1:0] spb, input logic [BSTEPS_W-1:0] steps);
      csr_we    <= 1'b1;
      csr_index <= CSR_SECONDS_PER_BEAT;
      csr_data  <= spb;
      @(negedge clock);
      csr_index <= CSR_BEND_STEPS;
      csr_data  <= {(CSR_DATA_W-BSTEPS_W)'($urandom), steps};
      @(negedge clock);
      csr_we     <= 1'b0;
      tempo_spb  = spb;
      ramp_steps = steps;
   endtask

   // Response side: random stalls, a long hold-off on request, none in the steady phase.
   initial begin : rsp_side
      int   hold_left;
      logic next_ready;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            next_ready = 1'b0;
            hold_left--;
         end else begin
            next_ready = steady_phase || ($urandom_range(99) >= 35);
         end
         @(negedge clock);
         rsp_bus.ready <= next_ready;
      end
   end

   always @(posedge clock) begin : check_beat
      ramp_event_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_events.size() == 0) begin
            report_mismatch("event with nothing awaited", rsp_bus.event_time, 0);
         end else begin
            want = awaited_events.pop_front();
            if (rsp_bus.event_time !== want.event_time)
               report_mismatch("event_time", rsp_bus.event_time, want.event_time);
            if (rsp_bus.bend_value !== want.bend_value)
               report_mismatch("bend_value", rsp_bus.bend_value, want.bend_value);
            if (rsp_bus.last_event !== want.last_event)
               report_mismatch("last_event", rsp_bus.last_event, want.last_event);
         end
      end
   end

   initial begin : stimulus
      int                  i, k, phase, counted, n_slides, drain;
      logic [SPB_W-1:0]    spb;
      logic [BSTEPS_W-1:0] steps;
      int unsigned         pick;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.start_beat   = '0;
      req_bus.end_beat     = '0;
      req_bus.from_pitch   = '0;
      req_bus.to_pitch     = '0;
      req_bus.curve_weight = '0;
      csr_we               = 1'b0;
      csr_index            = CSR_SECONDS_PER_BEAT;
      csr_data             = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The opening rows run on the register values left by reset.
      for (i = 0; i < N_DIRECTED; i++) begin
         if (directed_rows[i].spb != tempo_spb || directed_rows[i].steps != ramp_steps) begin
            settle_idle();
            program_ramp(directed_rows[i].spb, directed_rows[i].steps);
         end
         send_slide(directed_rows[i].slide, directed_rows[i].pinned,
                    directed_rows[i].first_bend, directed_rows[i].last_bend);
         idle_sender();
      end

      counted = 0;
      phase   = 0;
      while (counted < RANDOM_SLIDES) begin
         pick = $urandom_range(5);
         case (pick)
            0: spb = 20'd1;
            1: spb = 20'hFFFFF;
            2: spb = SPB_RESET;
            default: spb = SPB_W'($urandom_range(20'hFFFFF, 1));
         endcase
         if (phase >= 4 && $urandom_range(9) == 0)
            spb = '0;
         pick = $urandom_range(9);
         if (phase >= 4 && pick == 0)
            steps = 6'd63;
         else if (phase >= 4 && pick == 1)
            steps = BSTEPS_W'($urandom_range(62, 17));
         else
            steps = BSTEPS_W'($urandom_range(8));
         settle_idle();
         program_ramp(spb, steps);
         steady_phase = (phase == 1);
         n_slides = (spb == '0) ? 3 : (steps > 16) ? 5 : 30;
         for (k = 0; k < n_slides; k++) begin
            if (phase == 2 && k == 1)
               hold_wanted = 1'b1;
            if (phase == 3 && k == 15) begin
               req_bus.valid <= 1'b0;
               do @(negedge clock); while (awaited_events.size() != 0);
            end
            send_slide(random_slide(), 1'b0, '0, '0);
            if (tempo_spb != '0)
               counted++;
            idle_sender();
         end
         phase++;
      end
      steady_phase = 1'b0;

      req_bus.valid <= 1'b0;
      for (drain = 0; drain < DRAIN_LIMIT && awaited_events.size() != 0; drain++)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (awaited_events.size() != 0)
         report_mismatch("events never delivered", awaited_events.size(), 0);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/pbrg_pkg.sv
rtl/core/pbrg_if.sv
rtl/core/pbrg_mul.sv
rtl/core/pbrg_div.sv
rtl/core/portamento_bend_ramp_generator.sv
verif/portamento_bend_ramp_generator_tb.sv
